/* src/pec_pkg.sv */
// Shared widths, operation codes and memory interface types of the extreme counter.
package pec_pkg;

  localparam int MAX_SETS   = 1024;
  localparam int MAX_GROUPS = 256;

  localparam int SET_W   = $clog2(MAX_SETS);
  localparam int END_W   = $clog2(MAX_SETS + 1);
  localparam int GRP_W   = $clog2(MAX_GROUPS);
  localparam int OP_W    = 2;
  localparam int SCORE_W = 32;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 48;

  localparam logic [OP_W-1:0] OP_LOAD_SCORE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_END   = 2'd1;
  localparam logic [OP_W-1:0] OP_PERM_SCORE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ_SET   = 2'd3;

  typedef struct packed {
    logic [END_W-1:0] start;
    logic [END_W-1:0] fnn;
    logic [END_W-1:0] gend;
  } grp_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] neg_cnt;
    logic [CNT_W-1:0] pos_cnt;
    logic [SUM_W-1:0] neg_sum;
    logic [SUM_W-1:0] pos_sum;
  } stats_t;

  typedef struct packed {
    logic                      obs_we;
    logic [SET_W-1:0]          obs_waddr;
    logic signed [SCORE_W-1:0] obs_wdata;
    logic [SET_W-1:0]          obs_raddr;
    logic                      ext_we;
    logic [SET_W-1:0]          ext_waddr;
    logic [CNT_W-1:0]          ext_wdata;
    logic [SET_W-1:0]          ext_raddr;
    logic                      grp_we;
    logic [GRP_W-1:0]          grp_waddr;
    grp_entry_t                grp_wdata;
    logic [GRP_W-1:0]          grp_raddr;
    logic                      st_we;
    logic [GRP_W-1:0]          st_waddr;
    stats_t                    st_wdata;
    logic [GRP_W-1:0]          st_raddr;
  } mem_req_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] obs_rdata;
    logic [CNT_W-1:0]          ext_rdata;
    grp_entry_t                grp_rdata;
    stats_t                    st_rdata;
  } mem_rsp_t;

endpackage

/* src/permutation_extreme_counter_core.sv */
// Top level of the permutation extreme counter: sequencer plus its four memories.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries items with an
// operation code: load observed score, load group end, permutation score,
// read set result. Only a read yields an item on the output channel
// (out_valid_o / out_stall_i). An item moves when valid is high and stall low.
// Items are taken one at a time; in_stall_o stays high while one is at work.
// What each item does from acceptance until the next item can be taken:
//   load observed score: one write to the score memory.
//   load group end: a binary search for the group's first nonnegative slot,
//     each probe using the score memory read port, then a group table write.
//   permutation score: a statistics update, then for a loaded group a walk
//     over the slots of its same-sign side, using the score and count memory ports.
//   read set result: a count read, then a group table scan, one entry per
//     cycle, up to the first covering group, then a statistics read.
// A read's result sits in an output register; the block keeps taking items
// while it waits, but a further read holds until the register is free.
// After reset a clearing pass over all MAX_SETS (1024) slots zeroes the extreme
// counts and group statistics; no item is accepted during it.
module permutation_extreme_counter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pec_pkg::OP_W-1:0]           operation_i,
  input  logic [pec_pkg::SET_W-1:0]          set_index_i,
  input  logic [pec_pkg::GRP_W-1:0]          group_index_i,
  input  logic signed [pec_pkg::SCORE_W-1:0] score_i,
  input  logic [pec_pkg::END_W-1:0]          group_end_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pec_pkg::SET_W-1:0]          result_set_o,
  output logic [pec_pkg::CNT_W-1:0]          as_extreme_count_o,
  output logic [pec_pkg::CNT_W-1:0]          same_sign_count_o,
  output logic [pec_pkg::SUM_W-1:0]          same_sign_sum_o
);

  pec_pkg::mem_req_t req;
  pec_pkg::mem_rsp_t rsp;

  pec_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .set_index_i        (set_index_i),
    .group_index_i      (group_index_i),
    .score_i            (score_i),
    .group_end_i        (group_end_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_set_o       (result_set_o),
    .as_extreme_count_o (as_extreme_count_o),
    .same_sign_count_o  (same_sign_count_o),
    .same_sign_sum_o    (same_sign_sum_o),
    .req_o              (req),
    .rsp_i              (rsp)
  );

  // Observed scores, sorted ascending inside each group.
  pec_ram #(
    .WIDTH (pec_pkg::SCORE_W),
    .DEPTH (pec_pkg::MAX_SETS)
  ) u_obs_ram (
    .clk_i   (clk_i),
    .we_i    (req.obs_we),
    .waddr_i (req.obs_waddr),
    .wdata_i (req.obs_wdata),
    .raddr_i (req.obs_raddr),
    .rdata_o (rsp.obs_rdata)
  );

  // Per-slot extreme counts.
  pec_ram #(
    .WIDTH (pec_pkg::CNT_W),
    .DEPTH (pec_pkg::MAX_SETS)
  ) u_ext_ram (
    .clk_i   (clk_i),
    .we_i    (req.ext_we),
    .waddr_i (req.ext_waddr),
    .wdata_i (req.ext_wdata),
    .raddr_i (req.ext_raddr),
    .rdata_o (rsp.ext_rdata)
  );

  // Group bounds: start, first nonnegative slot, end.
  pec_ram #(
    .WIDTH ($bits(pec_pkg::grp_entry_t)),
    .DEPTH (pec_pkg::MAX_GROUPS)
  ) u_grp_ram (
    .clk_i   (clk_i),
    .we_i    (req.grp_we),
    .waddr_i (req.grp_waddr),
    .wdata_i (req.grp_wdata),
    .raddr_i (req.grp_raddr),
    .rdata_o (rsp.grp_rdata)
  );

  // Per-group same-sign counts and absolute sums.
  pec_ram #(
    .WIDTH ($bits(pec_pkg::stats_t)),
    .DEPTH (pec_pkg::MAX_GROUPS)
  ) u_stats_ram (
    .clk_i   (clk_i),
    .we_i    (req.st_we),
    .waddr_i (req.st_waddr),
    .wdata_i (req.st_wdata),
    .raddr_i (req.st_raddr),
    .rdata_o (rsp.st_rdata)
  );

endmodule

/* src/pec_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pec_ctrl.sv */
// Sequencer of the extreme counter: clearing pass, search, slot walk, group scan, result.
module pec_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pec_pkg::OP_W-1:0]           operation_i,
  input  logic [pec_pkg::SET_W-1:0]          set_index_i,
  input  logic [pec_pkg::GRP_W-1:0]          group_index_i,
  input  logic signed [pec_pkg::SCORE_W-1:0] score_i,
  input  logic [pec_pkg::END_W-1:0]          group_end_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pec_pkg::SET_W-1:0]          result_set_o,
  output logic [pec_pkg::CNT_W-1:0]          as_extreme_count_o,
  output logic [pec_pkg::CNT_W-1:0]          same_sign_count_o,
  output logic [pec_pkg::SUM_W-1:0]          same_sign_sum_o,
  output pec_pkg::mem_req_t                  req_o,
  input  pec_pkg::mem_rsp_t                  rsp_i
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_CLEAR     = 4'd0;
  localparam logic [ST_W-1:0] ST_IDLE      = 4'd1;
  localparam logic [ST_W-1:0] ST_SRCH      = 4'd2;
  localparam logic [ST_W-1:0] ST_SRCH_CHK  = 4'd3;
  localparam logic [ST_W-1:0] ST_SRCH_PREV = 4'd4;
  localparam logic [ST_W-1:0] ST_GRP_WR    = 4'd5;
  localparam logic [ST_W-1:0] ST_PERM_UPD  = 4'd6;
  localparam logic [ST_W-1:0] ST_WALK      = 4'd7;
  localparam logic [ST_W-1:0] ST_RD_EXT    = 4'd8;
  localparam logic [ST_W-1:0] ST_SCAN      = 4'd9;
  localparam logic [ST_W-1:0] ST_RD_ST     = 4'd10;
  localparam logic [ST_W-1:0] ST_RD_OUT    = 4'd11;

  localparam int END_W = pec_pkg::END_W;
  localparam int SET_W = pec_pkg::SET_W;
  localparam int GRP_W = pec_pkg::GRP_W;
  localparam int CNT_W = pec_pkg::CNT_W;
  localparam int SUM_W = pec_pkg::SUM_W;
  localparam int SCORE_W = pec_pkg::SCORE_W;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [SCORE_W-1:0] m);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(m);
    return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
  endfunction

  // Control state.
  logic [ST_W-1:0]             state_q, state_d;
  logic [SET_W-1:0]            clr_q, clr_d;
  logic [END_W-1:0]            prev_end_q, prev_end_d;
  logic [pec_pkg::MAX_GROUPS-1:0] loaded_q, loaded_d;
  logic                        pv_q, pv_d;
  logic                        out_valid_q, out_valid_d;

  // Working payload.
  logic [SET_W-1:0]            set_q, set_d;
  logic [GRP_W-1:0]            grp_q, grp_d;
  logic signed [SCORE_W-1:0]   score_q, score_d;
  logic                        neg_q, neg_d;
  logic [END_W-1:0]            start_q, start_d;
  logic [END_W-1:0]            end_q, end_d;
  logic [END_W-1:0]            lo_q, lo_d;
  logic [END_W-1:0]            hi_q, hi_d;
  logic [END_W-1:0]            mid_q, mid_d;
  logic [END_W-1:0]            fnn_q, fnn_d;
  logic [SET_W-1:0]            pa_q, pa_d;
  logic [GRP_W-1:0]            pg_q, pg_d;
  logic [GRP_W:0]              g_q, g_d;
  logic [CNT_W-1:0]            ext_q, ext_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [SUM_W-1:0]            sum_q, sum_d;
  logic [SET_W-1:0]            out_set_q, out_set_d;
  logic [CNT_W-1:0]            out_ext_q, out_ext_d;
  logic [CNT_W-1:0]            out_cnt_q, out_cnt_d;
  logic [SUM_W-1:0]            out_sum_q, out_sum_d;

  // Combinational helpers.
  logic [END_W:0]              mid_sum;
  logic [END_W-1:0]            mid;
  logic [END_W-1:0]            mid_m1;
  logic [END_W-1:0]            end_sat;
  logic [SCORE_W-1:0]          score_u;
  logic [SCORE_W-1:0]          mag;
  logic [END_W-1:0]            set_x;
  logic                        walk_issue;
  logic                        walk_hit;
  logic                        scan_issue;
  logic                        scan_cover;
  pec_pkg::stats_t             st_new;
  pec_pkg::mem_req_t           req;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (END_W+1)'(1);
  assign mid     = mid_sum[END_W:1];
  assign mid_m1  = mid_q - END_W'(1);
  assign end_sat = (group_end_i > END_W'(pec_pkg::MAX_SETS)) ? END_W'(pec_pkg::MAX_SETS)
                                                             : group_end_i;
  assign score_u = score_q;
  assign mag     = score_q[SCORE_W-1] ? (~score_u + SCORE_W'(1)) : score_u;
  assign set_x   = {1'b0, set_q};

  assign walk_issue = (lo_q < hi_q);
  assign walk_hit   = neg_q ? ($signed(score_q) <= $signed(rsp_i.obs_rdata))
                            : ($signed(score_q) >= $signed(rsp_i.obs_rdata));
  assign scan_issue = (g_q < (GRP_W+1)'(pec_pkg::MAX_GROUPS));
  assign scan_cover = pv_q && loaded_q[pg_q] &&
                      (set_x >= rsp_i.grp_rdata.start) && (set_x < rsp_i.grp_rdata.gend);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    prev_end_d  = prev_end_q;
    loaded_d    = loaded_q;
    pv_d        = pv_q;
    out_valid_d = out_valid_q;
    set_d       = set_q;
    grp_d       = grp_q;
    score_d     = score_q;
    neg_d       = neg_q;
    start_d     = start_q;
    end_d       = end_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    fnn_d       = fnn_q;
    pa_d        = pa_q;
    pg_d        = pg_q;
    g_d         = g_q;
    ext_d       = ext_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    out_set_d   = out_set_q;
    out_ext_d   = out_ext_q;
    out_cnt_d   = out_cnt_q;
    out_sum_d   = out_sum_q;
    st_new      = rsp_i.st_rdata;
    req         = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        req.ext_we    = 1'b1;
        req.ext_waddr = clr_q;
        if ({1'b0, clr_q} < (SET_W+1)'(pec_pkg::MAX_GROUPS)) begin
          req.st_we    = 1'b1;
          req.st_waddr = clr_q[GRP_W-1:0];
        end
        if (clr_q == SET_W'(pec_pkg::MAX_SETS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + SET_W'(1);
        end
      end

      ST_IDLE: begin
        // Reads are issued speculatively so their data is ready next cycle.
        req.ext_raddr = set_index_i;
        req.grp_raddr = group_index_i;
        req.st_raddr  = group_index_i;
        if (in_valid_i) begin
          set_d   = set_index_i;
          grp_d   = group_index_i;
          score_d = score_i;
          neg_d   = score_i[SCORE_W-1];
          unique case (operation_i)
            pec_pkg::OP_LOAD_SCORE: begin
              req.obs_we    = 1'b1;
              req.obs_waddr = set_index_i;
              req.obs_wdata = score_i;
            end
            pec_pkg::OP_LOAD_END: begin
              start_d    = prev_end_q;
              lo_d       = prev_end_q;
              end_d      = end_sat;
              hi_d       = end_sat;
              prev_end_d = end_sat;
              state_d    = ST_SRCH;
            end
            pec_pkg::OP_PERM_SCORE: begin
              state_d = ST_PERM_UPD;
            end
            pec_pkg::OP_READ_SET: begin
              state_d = ST_RD_EXT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // Binary search: the window is [lo, hi), probe at the floor midpoint.
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          req.obs_raddr = mid[SET_W-1:0];
          mid_d         = mid;
          state_d       = ST_SRCH_CHK;
        end else begin
          fnn_d   = end_q;
          state_d = ST_GRP_WR;
        end
      end

      ST_SRCH_CHK: begin
        if (!rsp_i.obs_rdata[SCORE_W-1]) begin
          if (mid_q == start_q) begin
            fnn_d   = mid_q;
            state_d = ST_GRP_WR;
          end else begin
            req.obs_raddr = mid_m1[SET_W-1:0];
            state_d       = ST_SRCH_PREV;
          end
        end else begin
          lo_d    = mid_q + END_W'(1);
          state_d = ST_SRCH;
        end
      end

      ST_SRCH_PREV: begin
        if (rsp_i.obs_rdata[SCORE_W-1]) begin
          fnn_d   = mid_q;
          state_d = ST_GRP_WR;
        end else begin
          hi_d    = mid_q;
          state_d = ST_SRCH;
        end
      end

      ST_GRP_WR: begin
        req.grp_we          = 1'b1;
        req.grp_waddr       = grp_q;
        req.grp_wdata.start = start_q;
        req.grp_wdata.fnn   = fnn_q;
        req.grp_wdata.gend  = end_q;
        loaded_d[grp_q]     = 1'b1;
        state_d             = ST_IDLE;
      end

      ST_PERM_UPD: begin
        if (neg_q) begin
          st_new.neg_cnt = sat_inc(rsp_i.st_rdata.neg_cnt);
          st_new.neg_sum = sat_add(rsp_i.st_rdata.neg_sum, mag);
          lo_d           = rsp_i.grp_rdata.start;
          hi_d           = rsp_i.grp_rdata.fnn;
        end else begin
          st_new.pos_cnt = sat_inc(rsp_i.st_rdata.pos_cnt);
          st_new.pos_sum = sat_add(rsp_i.st_rdata.pos_sum, mag);
          lo_d           = rsp_i.grp_rdata.fnn;
          hi_d           = rsp_i.grp_rdata.gend;
        end
        req.st_we    = 1'b1;
        req.st_waddr = grp_q;
        req.st_wdata = st_new;
        pv_d         = 1'b0;
        state_d      = loaded_q[grp_q] ? ST_WALK : ST_IDLE;
      end

      // One slot read per cycle; the slot read last cycle is compared and updated.
      ST_WALK: begin
        req.obs_raddr = lo_q[SET_W-1:0];
        req.ext_raddr = lo_q[SET_W-1:0];
        pv_d          = walk_issue;
        pa_d          = lo_q[SET_W-1:0];
        if (walk_issue) begin
          lo_d = lo_q + END_W'(1);
        end
        if (pv_q && walk_hit) begin
          req.ext_we    = 1'b1;
          req.ext_waddr = pa_q;
          req.ext_wdata = sat_inc(rsp_i.ext_rdata);
        end
        if (!walk_issue && !pv_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_RD_EXT: begin
        ext_d   = rsp_i.ext_rdata;
        g_d     = '0;
        pv_d    = 1'b0;
        state_d = ST_SCAN;
      end

      // Group table scan in index order; the first loaded group covering the slot wins.
      ST_SCAN: begin
        req.grp_raddr = g_q[GRP_W-1:0];
        pv_d          = scan_issue;
        pg_d          = g_q[GRP_W-1:0];
        if (scan_issue) begin
          g_d = g_q + (GRP_W+1)'(1);
        end
        if (scan_cover) begin
          req.st_raddr = pg_q;
          neg_d        = (set_x < rsp_i.grp_rdata.fnn);
          state_d      = ST_RD_ST;
        end else if (!scan_issue && !pv_q) begin
          cnt_d   = '0;
          sum_d   = '0;
          state_d = ST_RD_OUT;
        end
      end

      ST_RD_ST: begin
        cnt_d   = neg_q ? rsp_i.st_rdata.neg_cnt : rsp_i.st_rdata.pos_cnt;
        sum_d   = neg_q ? rsp_i.st_rdata.neg_sum : rsp_i.st_rdata.pos_sum;
        state_d = ST_RD_OUT;
      end

      ST_RD_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_set_d   = set_q;
          out_ext_d   = ext_q;
          out_cnt_d   = cnt_q;
          out_sum_d   = sum_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      prev_end_q  <= '0;
      loaded_q    <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      prev_end_q  <= prev_end_d;
      loaded_q    <= loaded_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q     <= set_d;
    grp_q     <= grp_d;
    score_q   <= score_d;
    neg_q     <= neg_d;
    start_q   <= start_d;
    end_q     <= end_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    fnn_q     <= fnn_d;
    pa_q      <= pa_d;
    pg_q      <= pg_d;
    g_q       <= g_d;
    ext_q     <= ext_d;
    cnt_q     <= cnt_d;
    sum_q     <= sum_d;
    out_set_q <= out_set_d;
    out_ext_q <= out_ext_d;
    out_cnt_q <= out_cnt_d;
    out_sum_q <= out_sum_d;
  end

  assign req_o              = req;
  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign result_set_o       = out_set_q;
  assign as_extreme_count_o = out_ext_q;
  assign same_sign_count_o  = out_cnt_q;
  assign same_sign_sum_o    = out_sum_q;

  // The slot being updated is always behind the slot being fetched.
  a_walk_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && req.ext_we) |-> (req.ext_waddr != req.ext_raddr))
    else $error("walk writes the slot it is reading");

  a_walk_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (hi_q <= END_W'(pec_pkg::MAX_SETS)))
    else $error("walk bound beyond the score store");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> (lo_q >= start_q && hi_q <= end_q))
    else $error("search window left the group");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RD_OUT))
    else $error("result raised outside a read");

endmodule
